// ===== hdl/u8dec_pkg.sv =====
// Package for the streaming UTF-8 decoder: result status codes, the decoder
// state, the result record and the per-byte step record.
// No dependencies; u8dec_step, u8dec_out_buf and the top level import it.
package u8dec_pkg;

  // Code point given on every error
  localparam logic [20:0] ReplacementCp = 21'h00FFFD;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INVALID    = 2'd1,
    ST_EXPECTED   = 2'd2,
    ST_UNEXPECTED = 2'd3
  } status_e;

  // Open-sequence state, all zero when no sequence is open
  typedef struct packed {
    logic [1:0]  bytes_owed;
    logic [20:0] partial_value;
    logic [2:0]  bytes_taken;
  } dec_state_t;

  // One decoded result
  typedef struct packed {
    logic [20:0] code_point;
    status_e     status;
    logic [2:0]  byte_count;
    logic        last_of_run;
  } result_t;

  // Everything one byte produces: up to two results and the next state
  typedef struct packed {
    logic       res0_valid;
    logic       res1_valid;
    result_t    res0;
    result_t    res1;
    dec_state_t nxt;
  } step_t;

endpackage

// ===== hdl/u8dec_byte_if.sv =====
// Byte channel of the UTF-8 decoder: valid/ready plus one raw stream byte.
// Stand-alone; no package needed.
interface u8dec_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== hdl/u8dec_res_if.sv =====
// Result channel of the UTF-8 decoder: valid/ready plus one decoded result.
// Stand-alone; status codes are those of u8dec_pkg.
interface u8dec_res_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [1:0]  status;
  logic [2:0]  byte_count;
  logic        last_of_run;

  modport source (output valid, output code_point, output status, output byte_count,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_point, input status, input byte_count,
                  input last_of_run, output ready);
endinterface

// ===== hdl/u8dec_step.sv =====
// Combinational decode of one byte against the open-sequence state.
// Depends on u8dec_pkg.
module u8dec_step (
  input  u8dec_pkg::dec_state_t state_i,
  input  logic [7:0]            data_byte_i,
  output u8dec_pkg::step_t      step_o
);
  import u8dec_pkg::*;

  typedef struct packed {
    logic       emit;
    result_t    res;
    dec_state_t nxt;
  } fresh_t;

  // Decode a byte with no sequence open
  function automatic fresh_t decode_fresh(input logic [7:0] b);
    fresh_t f;
    f.emit             = 1'b1;
    f.res.code_point   = ReplacementCp;
    f.res.status       = ST_INVALID;
    f.res.byte_count   = 3'd1;
    f.res.last_of_run  = 1'b1;
    f.nxt              = '0;
    if (!b[7]) begin
      f.res.code_point = {13'd0, b};
      f.res.status     = ST_OK;
    end else if (!b[6]) begin
      f.res.status     = ST_UNEXPECTED;
    end else if (!b[5]) begin
      f.emit                = 1'b0;
      f.nxt.bytes_owed      = 2'd1;
      f.nxt.partial_value   = {16'd0, b[4:0]};
      f.nxt.bytes_taken     = 3'd1;
    end else if (!b[4]) begin
      f.emit                = 1'b0;
      f.nxt.bytes_owed      = 2'd2;
      f.nxt.partial_value   = {17'd0, b[3:0]};
      f.nxt.bytes_taken     = 3'd1;
    end else if (!b[3]) begin
      f.emit                = 1'b0;
      f.nxt.bytes_owed      = 2'd3;
      f.nxt.partial_value   = {18'd0, b[2:0]};
      f.nxt.bytes_taken     = 3'd1;
    end
    return f;
  endfunction

  fresh_t      fresh;
  logic        is_cont;
  logic [1:0]  owed_dec;
  logic [20:0] value_ext;
  logic [2:0]  taken_inc;

  // Step: fresh decode, continuation, or broken sequence then fresh decode
  always_comb begin
    fresh     = decode_fresh(data_byte_i);
    is_cont   = (data_byte_i[7:6] == 2'b10);
    owed_dec  = state_i.bytes_owed - 2'd1;
    value_ext = {state_i.partial_value[14:0], data_byte_i[5:0]};
    taken_inc = state_i.bytes_taken + 3'd1;

    step_o            = '0;
    step_o.res0       = fresh.res;
    step_o.res1       = fresh.res;
    step_o.nxt        = state_i;

    if (state_i.bytes_owed == 2'd0) begin
      step_o.res0_valid = fresh.emit;
      step_o.nxt        = fresh.nxt;
    end else if (is_cont) begin
      if (owed_dec == 2'd0) begin
        step_o.res0_valid       = 1'b1;
        step_o.res0.code_point  = value_ext;
        step_o.res0.status      = ST_OK;
        step_o.res0.byte_count  = taken_inc;
        step_o.res0.last_of_run = 1'b1;
        step_o.nxt              = '0;
      end else begin
        step_o.nxt.bytes_owed    = owed_dec;
        step_o.nxt.partial_value = value_ext;
        step_o.nxt.bytes_taken   = taken_inc;
      end
    end else begin
      // close the open sequence, then decode the byte afresh
      step_o.res0_valid       = 1'b1;
      step_o.res0.code_point  = ReplacementCp;
      step_o.res0.status      = (data_byte_i[7:3] == 5'b11111) ? ST_INVALID : ST_EXPECTED;
      step_o.res0.byte_count  = state_i.bytes_taken;
      step_o.res0.last_of_run = !fresh.emit;
      step_o.res1_valid       = fresh.emit;
      step_o.nxt              = fresh.nxt;
    end
  end

endmodule

// ===== hdl/u8dec_out_buf.sv =====
// Two-entry result buffer of the UTF-8 decoder; takes zero, one or two
// results per cycle and presents one per transfer. Depends on u8dec_pkg.
module u8dec_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  u8dec_pkg::step_t     step_i,
  output logic                 fits_o,
  u8dec_res_if.source          res_o
);
  import u8dec_pkg::*;

  result_t    res_q [2];
  result_t    res_d [2];
  logic [1:0] count_q, count_d;
  logic [1:0] count_pop;
  logic [1:0] n_new;
  logic       pop;

  // Output side
  assign pop               = res_o.valid && res_o.ready;
  assign res_o.valid       = (count_q != 2'd0);
  assign res_o.code_point  = res_q[0].code_point;
  assign res_o.status      = res_q[0].status;
  assign res_o.byte_count  = res_q[0].byte_count;
  assign res_o.last_of_run = res_q[0].last_of_run;

  // Room check, counting the entry leaving this cycle
  assign count_pop = count_q - {1'b0, pop};
  assign n_new     = {1'b0, step_i.res0_valid} + {1'b0, step_i.res1_valid};
  assign fits_o    = (2'd2 - count_pop) >= n_new;

  // Shift out on pop, then append new results
  always_comb begin
    res_d[0] = pop ? res_q[1] : res_q[0];
    res_d[1] = res_q[1];
    count_d  = count_pop;
    if (push_i && step_i.res0_valid) begin
      if (count_pop == 2'd0) begin
        res_d[0] = step_i.res0;
        if (step_i.res1_valid) begin
          res_d[1] = step_i.res1;
        end
      end else begin
        res_d[1] = step_i.res0;
      end
      count_d = count_pop + n_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q[0] <= res_d[0];
    res_q[1] <= res_d[1];
  end

endmodule

// ===== hdl/utf8_stream_decoder.sv =====
// Streaming UTF-8 decoder, top level: input register, decode step, result buffer.
// Depends on u8dec_pkg, u8dec_byte_if, u8dec_res_if, u8dec_step, u8dec_out_buf.
//
// Takes one byte per transfer on byte_i and gives decoded code points on res_o,
// U+FFFD with an error status on malformed input. Throughput is one byte per
// cycle while res_o is ready. A byte that breaks an open sequence and also
// yields a result of its own gives two results. The two-entry result buffer
// drains one per cycle, so the surplus result stays buffered, and the next
// byte that gives two results waits for room, unless a byte that gives no
// result has let the buffer drain first. A result passes the input register
// and then the result buffer before it can be transferred. Bytes that only
// open or extend a sequence give no result. A sequence left open at the end
// of the stream is held, not flushed.
module utf8_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8dec_byte_if.sink  byte_i,
  u8dec_res_if.source res_o
);
  import u8dec_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  dec_state_t state_q;
  step_t      step;
  logic       fits;
  logic       process;

  assign process      = in_valid_q && fits;
  assign byte_i.ready = !in_valid_q || process;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.valid && byte_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (process) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
    end
  end

  // Decode one byte against the open sequence
  u8dec_step u_step (
    .state_i     (state_q),
    .data_byte_i (in_byte_q),
    .step_o      (step)
  );

  // Open-sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (process) begin
      state_q <= step.nxt;
    end
  end

  // Result buffer
  u8dec_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (process),
    .step_i (step),
    .fits_o (fits),
    .res_o  (res_o)
  );

endmodule
